[hw/rtl/bmhpq_pkg.sv]
// ============================================================================
// bmhpq_pkg
// Shared types and codes for the binary max-heap priority queue: operation
// and status codes, controller states and the command/status bundles.
// ============================================================================
package bmhpq_pkg;

  // Operation codes on the input channel
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_CHK,
    S_DN_RL,
    S_DN_RR,
    S_ROOT_RD,
    S_OUT
  } state_t;

  // Heap memory read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT,
    RD_LAST,
    RD_ROOT
  } rd_sel_t;

  // Heap memory write data select; the write address is always the hole
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CARRY,
    WR_RDATA,
    WR_PICK
  } wr_sel_t;

  // Hole position update select
  typedef enum logic [1:0] {
    MV_NONE,
    MV_PARENT,
    MV_LEFT,
    MV_PICK
  } mv_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_in;      // latch the input fields
    logic    latch_status; // latch the status code of the operation
    logic    ins_begin;    // carry the new pair, hole at count, count up
    logic    del_begin;    // count down
    logic    take_carry;   // carry the last pair, hole at root
    logic    keep_left;    // hold the left child just read
    rd_sel_t rd;
    wr_sel_t wr;
    mv_sel_t mv;
    logic    load_out;     // load the result register
  } bmhpq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic err;          // operation is rejected
    logic op_del;       // latched operation is a delete
    logic pos_zero;     // hole is at the root
    logic left_absent;  // left child of the hole is beyond the count
    logic right_absent; // right child of the hole is beyond the count
    logic up_swap;      // carried key beats the parent just read
    logic stop_left;    // left child just read is below the carried key
    logic stop_pick;    // larger child is below the carried key
  } bmhpq_stat_t;

  localparam bmhpq_cmd_t CMD_NOP = '{
    load_in:      1'b0,
    latch_status: 1'b0,
    ins_begin:    1'b0,
    del_begin:    1'b0,
    take_carry:   1'b0,
    keep_left:    1'b0,
    rd:           RD_NONE,
    wr:           WR_NONE,
    mv:           MV_NONE,
    load_out:     1'b0
  };

endpackage

[hw/rtl/binary_max_heap_priority_queue.sv]
// ============================================================================
// binary_max_heap_priority_queue
// Max-priority queue of (key, element) pairs held in an array binary heap.
// Each insert or delete-max returns status, the root pair and the count.
// ============================================================================
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------
//   input   | in_valid / in_ready  | operation, key, element
//   output  | out_valid/ out_ready | status, top_key, top_element,
//           |                      | entry_count
//
// One operation at a time. A rejected operation goes straight to the root
// read; an insert sifts up level by level and a delete sifts down, with up
// to log2(DEPTH) levels. Each step is one heap memory access with its
// registered read. Reset clears the count and the handshakes; the heap
// memory is not cleared. A new operation is taken while a result waits in
// the output register; the next result waits only if that one is still
// not taken.
module binary_max_heap_priority_queue #(
  parameter int DEPTH      = 64,
  parameter int KEY_WIDTH  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] key,
  input  logic [31:0] element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] top_key,
  output logic [31:0] top_element,
  output logic [6:0]  entry_count
);

  bmhpq_pkg::bmhpq_cmd_t  cmd;
  bmhpq_pkg::bmhpq_stat_t stat;

  // Sequence control
  bmhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Heap storage and compares
  bmhpq_dpath #(
    .DEPTH      (DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .key         (key),
    .element     (element),
    .status      (status),
    .top_key     (top_key),
    .top_element (top_element),
    .entry_count (entry_count)
  );

endmodule

[hw/rtl/bmhpq_dpath.sv]
// ============================================================================
// bmhpq_dpath
// Heap datapath: input and result registers, pair count, carried pair and
// hole position, heap memory with registered read, and the key compares.
// ============================================================================
module bmhpq_dpath #(
  parameter int DEPTH      = 64,
  parameter int KEY_WIDTH  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bmhpq_pkg::bmhpq_cmd_t  cmd,
  output bmhpq_pkg::bmhpq_stat_t stat,
  input  logic                   operation,
  input  logic [15:0]            key,
  input  logic [31:0]            element,
  output logic [1:0]             status,
  output logic [15:0]            top_key,
  output logic [31:0]            top_element,
  output logic [6:0]             entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]  k;
    logic [ELEM_WIDTH-1:0] e;
  } pair_t;

  logic                     op_q;
  logic [KEY_WIDTH-1:0]     key_q;
  logic [ELEM_WIDTH-1:0]    elem_q;
  bmhpq_pkg::status_t       code;
  bmhpq_pkg::status_t       code_q;
  logic [CW-1:0]            count;
  pair_t                    carry;
  pair_t                    lreg;
  pair_t                    rdata;
  logic [AW-1:0]            pos;
  pair_t                    mem [DEPTH];

  logic [IW-1:0]            count_x;
  logic [IW-1:0]            left;
  logic [IW-1:0]            right;
  logic [AW-1:0]            parent;
  logic [AW-1:0]            last_idx;
  logic                     pick_right;
  pair_t                    pick_pair;
  logic [AW-1:0]            pick_idx;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  pair_t                    wr_data;

  logic [1:0]               out_status;
  logic [15:0]              out_key;
  logic [31:0]              out_elem;
  logic [6:0]               out_count;

  // Index arithmetic around the hole
  assign count_x  = IW'(count);
  assign left     = IW'({pos, 1'b1});
  assign right    = left + IW'(1);
  assign parent   = (pos - AW'(1)) >> 1;
  assign last_idx = AW'(count - CW'(1));

  // Pick the larger child, left wins ties
  assign pick_right = rdata.k > lreg.k;
  assign pick_pair  = pick_right ? rdata : lreg;
  assign pick_idx   = pick_right ? right[AW-1:0] : left[AW-1:0];

  // Status code of the latched operation
  always_comb begin
    if (op_q == bmhpq_pkg::OP_INSERT) begin
      if (key_q == '0 || elem_q == '0) begin
        code = bmhpq_pkg::STAT_INVALID;
      end else if (count == CW'(DEPTH)) begin
        code = bmhpq_pkg::STAT_FULL;
      end else begin
        code = bmhpq_pkg::STAT_DONE;
      end
    end else begin
      if (count == '0) begin
        code = bmhpq_pkg::STAT_EMPTY;
      end else begin
        code = bmhpq_pkg::STAT_DONE;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    stat.err          = (code != bmhpq_pkg::STAT_DONE);
    stat.op_del       = (op_q == bmhpq_pkg::OP_DELETE);
    stat.pos_zero     = (pos == '0);
    stat.left_absent  = (left >= count_x);
    stat.right_absent = (right >= count_x);
    stat.up_swap      = carry.k > rdata.k;
    stat.stop_left    = rdata.k < carry.k;
    stat.stop_pick    = pick_pair.k < carry.k;
  end

  // Select the read address
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd.rd)
      bmhpq_pkg::RD_PARENT: rd_addr = parent;
      bmhpq_pkg::RD_LEFT:   rd_addr = left[AW-1:0];
      bmhpq_pkg::RD_RIGHT:  rd_addr = right[AW-1:0];
      bmhpq_pkg::RD_LAST:   rd_addr = last_idx;
      bmhpq_pkg::RD_ROOT:   rd_addr = '0;
      default:              rd_en   = 1'b0;
    endcase
  end

  // Select the write data
  always_comb begin
    wr_en   = 1'b1;
    wr_data = carry;
    case (cmd.wr)
      bmhpq_pkg::WR_CARRY: wr_data = carry;
      bmhpq_pkg::WR_RDATA: wr_data = rdata;
      bmhpq_pkg::WR_PICK:  wr_data = pick_pair;
      default:             wr_en   = 1'b0;
    endcase
  end

  // Heap memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Count of held pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_begin) begin
      count <= count + CW'(1);
    end else if (cmd.del_begin) begin
      count <= count - CW'(1);
    end
  end

  // Input fields, status code, carried pair, hole and left child
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= operation;
      key_q  <= KEY_WIDTH'(key);
      elem_q <= ELEM_WIDTH'(element);
    end
    if (cmd.latch_status) begin
      code_q <= code;
    end
    if (cmd.keep_left) begin
      lreg <= rdata;
    end
    if (cmd.ins_begin) begin
      carry.k <= key_q;
      carry.e <= elem_q;
      pos     <= AW'(count);
    end else if (cmd.take_carry) begin
      carry <= rdata;
      pos   <= '0;
    end else begin
      case (cmd.mv)
        bmhpq_pkg::MV_PARENT: pos <= parent;
        bmhpq_pkg::MV_LEFT:   pos <= left[AW-1:0];
        bmhpq_pkg::MV_PICK:   pos <= pick_idx;
        default:              pos <= pos;
      endcase
    end
  end

  // Result register, root read last
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= code_q;
      out_count  <= 7'(count);
      if (count == '0) begin
        out_key  <= '0;
        out_elem <= '0;
      end else begin
        out_key  <= 16'(rdata.k);
        out_elem <= 32'(rdata.e);
      end
    end
  end

  assign status      = out_status;
  assign top_key     = out_key;
  assign top_element = out_elem;
  assign entry_count = out_count;

endmodule

[hw/rtl/bmhpq_ctrl.sv]
// ============================================================================
// bmhpq_ctrl
// Heap controller: takes one operation at a time, steps the sift up or sift
// down through the datapath, then reads the root and hands off the result.
// ============================================================================
module bmhpq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  bmhpq_pkg::bmhpq_stat_t stat,
  output bmhpq_pkg::bmhpq_cmd_t  cmd
);

  bmhpq_pkg::state_t state;
  bmhpq_pkg::state_t state_next;
  logic              out_free;

  // The result register is free once empty or being taken
  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmhpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = bmhpq_pkg::CMD_NOP;
    in_ready   = 1'b0;
    case (state)
      bmhpq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = bmhpq_pkg::S_CHECK;
        end
      end
      bmhpq_pkg::S_CHECK: begin
        cmd.latch_status = 1'b1;
        if (stat.err) begin
          state_next = bmhpq_pkg::S_ROOT_RD;
        end else if (stat.op_del) begin
          cmd.del_begin = 1'b1;
          cmd.rd        = bmhpq_pkg::RD_LAST;
          state_next    = bmhpq_pkg::S_DN_LAST;
        end else begin
          cmd.ins_begin = 1'b1;
          state_next    = bmhpq_pkg::S_UP_CHK;
        end
      end
      // Sift up: read the parent of the hole unless at the root
      bmhpq_pkg::S_UP_CHK: begin
        if (stat.pos_zero) begin
          cmd.wr     = bmhpq_pkg::WR_CARRY;
          state_next = bmhpq_pkg::S_ROOT_RD;
        end else begin
          cmd.rd     = bmhpq_pkg::RD_PARENT;
          state_next = bmhpq_pkg::S_UP_CMP;
        end
      end
      // Move the parent down or settle the carried pair
      bmhpq_pkg::S_UP_CMP: begin
        if (stat.up_swap) begin
          cmd.wr     = bmhpq_pkg::WR_RDATA;
          cmd.mv     = bmhpq_pkg::MV_PARENT;
          state_next = bmhpq_pkg::S_UP_CHK;
        end else begin
          cmd.wr     = bmhpq_pkg::WR_CARRY;
          state_next = bmhpq_pkg::S_ROOT_RD;
        end
      end
      // Sift down: carry the last pair from the root
      bmhpq_pkg::S_DN_LAST: begin
        cmd.take_carry = 1'b1;
        state_next     = bmhpq_pkg::S_DN_CHK;
      end
      bmhpq_pkg::S_DN_CHK: begin
        if (stat.left_absent) begin
          cmd.wr     = bmhpq_pkg::WR_CARRY;
          state_next = bmhpq_pkg::S_ROOT_RD;
        end else begin
          cmd.rd     = bmhpq_pkg::RD_LEFT;
          state_next = bmhpq_pkg::S_DN_RL;
        end
      end
      // Left child in hand; fetch the right one or decide on the left alone
      bmhpq_pkg::S_DN_RL: begin
        cmd.keep_left = 1'b1;
        if (!stat.right_absent) begin
          cmd.rd     = bmhpq_pkg::RD_RIGHT;
          state_next = bmhpq_pkg::S_DN_RR;
        end else if (stat.stop_left) begin
          cmd.wr     = bmhpq_pkg::WR_CARRY;
          state_next = bmhpq_pkg::S_ROOT_RD;
        end else begin
          cmd.wr     = bmhpq_pkg::WR_RDATA;
          cmd.mv     = bmhpq_pkg::MV_LEFT;
          state_next = bmhpq_pkg::S_DN_CHK;
        end
      end
      bmhpq_pkg::S_DN_RR: begin
        if (stat.stop_pick) begin
          cmd.wr     = bmhpq_pkg::WR_CARRY;
          state_next = bmhpq_pkg::S_ROOT_RD;
        end else begin
          cmd.wr     = bmhpq_pkg::WR_PICK;
          cmd.mv     = bmhpq_pkg::MV_PICK;
          state_next = bmhpq_pkg::S_DN_CHK;
        end
      end
      bmhpq_pkg::S_ROOT_RD: begin
        cmd.rd     = bmhpq_pkg::RD_ROOT;
        state_next = bmhpq_pkg::S_OUT;
      end
      // Hold the root read until the result register frees up
      bmhpq_pkg::S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = bmhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bmhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
